>>> rtl/pnew_pkg.sv
// Package for the pixel neighbor edge weight block.
// Shared types, register indexes and fixed-point constants; no dependencies.
package pnew_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 2048;

	localparam logic [11:0] DEF_FRAME_WIDTH  = 12'd640;
	localparam logic [15:0] DEF_FRAME_HEIGHT = 16'd480;
	localparam logic [23:0] DEF_BETA_Q8      = 24'd25600;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BETA_Q8      = 2'd2;

	// 256 * 65025 and sixteen times that
	localparam logic [23:0] DIV_CONST = 24'd16646400;
	localparam logic [39:0] N_LIMIT   = 40'd266342400;
	localparam logic [31:0] Q31_ONE   = 32'h8000_0000;
	localparam logic [63:0] Q31_HALF  = 64'h0000_0000_4000_0000;
	localparam logic [31:0] MICRO     = 32'd1000000;
	localparam logic [3:0]  TAYLOR_N  = 4'd10;

	// 65025 and ceil(2^47 / 65025); the product's bits from 47 up give the
	// exact quotient for any dividend below 2^32
	localparam logic [31:0] D_255SQ  = 32'd65025;
	localparam logic [31:0] RECIP_D  = 32'd2164359683;

	typedef enum logic [2:0] {
		C_IDLE,
		C_PUSH,
		C_WSTART,
		C_WWAIT,
		C_OUT
	} ctl_state_t;

	typedef enum logic [3:0] {
		W_IDLE,
		W_MUL1,
		W_MUL2,
		W_QMUL,
		W_RMUL,
		W_TMUL,
		W_KDIV,
		W_CLAMP,
		W_SQ,
		W_FIN
	} wph_t;

	typedef struct packed {
		logic accept;
		logic push;
		logic w_start;
		logic w_store;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic emit;
		logic w_done;
		logic nb_last;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/pnew_in_if.sv
// Input channel of the edge weight block: one pixel or drain item.
// Stand-alone interface, no dependencies.
interface pnew_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, func, red, green, blue, input ready);
	modport sink (input valid, func, red, green, blue, output ready);
endinterface

>>> rtl/pnew_out_if.sv
// Result channel of the edge weight block: eight weights, their sum, frame end.
// Stand-alone interface, no dependencies.
interface pnew_out_if;
	logic        valid;
	logic        ready;
	logic [19:0] w_up;
	logic [19:0] w_up_left;
	logic [19:0] w_left;
	logic [19:0] w_down_left;
	logic [19:0] w_down;
	logic [19:0] w_down_right;
	logic [19:0] w_right;
	logic [19:0] w_up_right;
	logic [22:0] degree;
	logic        last_of_frame;

	modport source (output valid, w_up, w_up_left, w_left, w_down_left, w_down,
		w_down_right, w_right, w_up_right, degree, last_of_frame, input ready);
	modport sink (input valid, w_up, w_up_left, w_left, w_down_left, w_down,
		w_down_right, w_right, w_up_right, degree, last_of_frame, output ready);
endinterface

>>> rtl/pnew_wunit.sv
// Iterative weight unit: one shared 32x32 multiplier, divisions by reciprocal.
// Forms round(1e6*exp(-beta*m*m/(256*65025)))+1; uses pnew_pkg.
module pnew_wunit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] pix_a,
	input  logic [23:0] pix_b,
	input  logic [23:0] beta,
	output logic        done,
	output logic [19:0] wt
);
	import pnew_pkg::*;

	wph_t        ph_q;
	logic [7:0]  m_q;
	logic [31:0] bm_q;
	logic [31:0] y_q;
	logic [16:0] q_q;
	logic [1:0]  ch_q;
	logic [30:0] t16_q;
	logic [31:0] term_q;
	logic [31:0] d_q;
	logic signed [33:0] s_q;
	logic [31:0] e_q;
	logic [3:0]  k_q;
	logic [1:0]  sq_q;
	logic        done_q;
	logic [19:0] wt_q;

	logic [7:0]  m_in;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] mul_r;
	logic [31:0] rem_d;
	logic [31:0] recip_k;
	logic [2:0]  lg_k;
	logic [31:0] kq;

	function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
		absdiff = (x > y) ? x - y : y - x;
	endfunction

	always_comb begin
		logic [7:0] d0, d1, d2, mx;
		d0 = absdiff(pix_a[7:0], pix_b[7:0]);
		d1 = absdiff(pix_a[15:8], pix_b[15:8]);
		d2 = absdiff(pix_a[23:16], pix_b[23:16]);
		mx = (d1 > d0) ? d1 : d0;
		m_in = (d2 > mx) ? d2 : mx;
	end

	// ceil(2^(31+L) / k) with L = ceil(log2 k): exact for terms below 2^31
	always_comb begin
		unique case (k_q)
			4'd2:    begin recip_k = 32'd2147483648; lg_k = 3'd1; end
			4'd3:    begin recip_k = 32'd2863311531; lg_k = 3'd2; end
			4'd4:    begin recip_k = 32'd2147483648; lg_k = 3'd2; end
			4'd5:    begin recip_k = 32'd3435973837; lg_k = 3'd3; end
			4'd6:    begin recip_k = 32'd2863311531; lg_k = 3'd3; end
			4'd7:    begin recip_k = 32'd2454267027; lg_k = 3'd3; end
			4'd8:    begin recip_k = 32'd2147483648; lg_k = 3'd3; end
			4'd9:    begin recip_k = 32'd3817748708; lg_k = 3'd4; end
			4'd10:   begin recip_k = 32'd3435973837; lg_k = 3'd4; end
			default: begin recip_k = 32'd2147483648; lg_k = 3'd0; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ph_q)
			W_MUL1: begin
				mul_a = {8'd0, beta};
				mul_b = {24'd0, m_q};
			end
			W_MUL2: begin
				mul_a = bm_q;
				mul_b = {24'd0, m_q};
			end
			W_QMUL: begin
				mul_a = y_q;
				mul_b = RECIP_D;
			end
			W_RMUL: begin
				mul_a = {15'd0, q_q};
				mul_b = D_255SQ;
			end
			W_TMUL: begin
				mul_a = term_q;
				mul_b = {1'b0, t16_q};
			end
			W_KDIV: begin
				mul_a = d_q;
				mul_b = recip_k;
			end
			W_SQ: begin
				mul_a = e_q;
				mul_b = e_q;
			end
			W_FIN: begin
				mul_a = e_q;
				mul_b = MICRO;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign mul_r = mul_p + Q31_HALF;
	assign rem_d = y_q - mul_p[31:0];
	assign kq    = 32'(mul_p[63:31] >> lg_k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= W_IDLE;
			done_q <= 1'b0;
		end else begin
			unique case (ph_q)
				W_IDLE: begin
					if (start) begin
						ph_q   <= W_MUL1;
						done_q <= 1'b0;
					end
				end
				W_MUL1: ph_q <= W_MUL2;
				W_MUL2: begin
					if (mul_p[39:0] >= N_LIMIT) begin
						ph_q   <= W_IDLE;
						done_q <= 1'b1;
					end else begin
						ph_q <= W_QMUL;
					end
				end
				W_QMUL: begin
					if (ch_q == 2'd2) ph_q <= W_TMUL;
					else ph_q <= W_RMUL;
				end
				W_RMUL: ph_q <= W_QMUL;
				W_TMUL: ph_q <= W_KDIV;
				W_KDIV: begin
					if (k_q == TAYLOR_N) ph_q <= W_CLAMP;
					else ph_q <= W_TMUL;
				end
				W_CLAMP: ph_q <= W_SQ;
				W_SQ: begin
					if (sq_q == 2'd3) ph_q <= W_FIN;
				end
				W_FIN: begin
					ph_q   <= W_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= W_IDLE;
			endcase
		end
	end

	// n * 2^19 / 65025 in three radix steps: 2^19, 2^3, then the last 3 bits
	always_ff @(posedge clk) begin
		unique case (ph_q)
			W_IDLE: begin
				if (start) m_q <= m_in;
			end
			W_MUL1: bm_q <= mul_p[31:0];
			W_MUL2: begin
				if (mul_p[39:0] >= N_LIMIT) begin
					wt_q <= 20'd1;
				end else begin
					y_q   <= {4'd0, mul_p[27:0]};
					ch_q  <= 2'd0;
					t16_q <= '0;
				end
			end
			W_QMUL: begin
				q_q <= mul_p[63:47];
				if (ch_q == 2'd0) begin
					t16_q <= {mul_p[58:47], 19'd0};
				end else if (ch_q == 2'd1) begin
					t16_q <= t16_q + {12'd0, mul_p[62:47], 3'd0};
				end else begin
					t16_q  <= t16_q + {28'd0, mul_p[49:47]};
					term_q <= Q31_ONE;
					s_q    <= 34'(Q31_ONE);
					k_q    <= 4'd1;
				end
			end
			W_RMUL: begin
				if (ch_q == 2'd0) y_q <= {rem_d[15:0], 16'd0};
				else y_q <= {13'd0, rem_d[15:0], 3'd0};
				ch_q <= ch_q + 2'd1;
			end
			W_TMUL: d_q <= mul_p[62:31];
			W_KDIV: begin
				term_q <= kq;
				// odd terms subtract, even terms add
				if (k_q[0]) s_q <= s_q - $signed({2'b00, kq});
				else s_q <= s_q + $signed({2'b00, kq});
				k_q <= k_q + 4'd1;
			end
			W_CLAMP: begin
				e_q  <= s_q[33] ? 32'd0 : s_q[31:0];
				sq_q <= '0;
			end
			W_SQ: begin
				e_q  <= mul_r[62:31];
				sq_q <= sq_q + 2'd1;
			end
			W_FIN: wt_q <= 20'(mul_r[62:31] + 32'd1);
			default: m_q <= m_q;
		endcase
	end

	assign done = done_q;
	assign wt   = wt_q;
endmodule

>>> rtl/pnew_dp.sv
// Datapath of the edge weight block: line stores, 3x3 window, position
// counters, configuration, weight unit and result register; uses pnew_pkg.
module pnew_dp #(
	parameter int unsigned MAX_WIDTH = pnew_pkg::MAX_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pnew_pkg::cmd_t cmd,
	output pnew_pkg::sts_t sts,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_wdata,
	input  logic          func,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	pnew_out_if.source    res_out
);
	import pnew_pkg::*;

	localparam int unsigned AW  = $clog2(MAX_WIDTH);
	localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WW  = (WB > 12) ? WB : 12;
	localparam int unsigned FW  = $clog2(MAX_WIDTH + 3);

	logic [11:0] fw_q;
	logic [15:0] fh_q;
	logic [23:0] beta_q;

	logic [23:0] near_mem [MAX_WIDTH];
	logic [23:0] far_mem  [MAX_WIDTH];
	logic [23:0] top_s1;
	logic [23:0] mid_s1;
	logic [23:0] pix_q;
	logic [23:0] win_q [3][3];

	logic [AW-1:0] in_col_q;
	logic [15:0]   in_row_q;
	logic [AW-1:0] out_col_q;
	logic [15:0]   out_row_q;
	logic [FW-1:0] fill_q;
	logic          drain_q;

	logic [2:0]  nb_q;
	logic [19:0] wts_q [8];
	logic [22:0] deg_q;
	logic        out_valid_q;

	logic [WW-1:0] eff_w;
	logic [15:0]   eff_h;
	logic          is_pix;
	logic          restart_now;
	logic          skip;
	logic [AW-1:0] rd_addr;
	logic          in_col_wrap;
	logic          in_row_wrap;
	logic [FW-1:0] fill_nx;
	logic          last_c;
	logic          last_r;
	logic          nb_ok;
	logic [23:0]   nb_pix;
	logic          wu_done;
	logic [19:0]   wu_wt;
	logic [19:0]   wt_now;
	logic          cfg_restart;

	always_comb begin
		if (fw_q == '0) eff_w = WW'(1);
		else if (WW'(fw_q) > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
		else eff_w = WW'(fw_q);
	end
	assign eff_h = (fh_q == '0) ? 16'd1 : fh_q;

	assign is_pix      = !func;
	assign restart_now = is_pix && drain_q;
	// a drain only starts a flush right after a frame's last pixel
	assign skip = !is_pix && !drain_q && !(in_col_q == '0 && in_row_q == '0 && fill_q != '0);
	assign rd_addr = restart_now ? '0 : in_col_q;

	assign in_col_wrap = (WW'(in_col_q) + WW'(1)) >= eff_w;
	assign in_row_wrap = ({1'b0, in_row_q} + 17'd1) >= {1'b0, eff_h};
	assign fill_nx = (fill_q < (FW'(eff_w) + FW'(2))) ? fill_q + FW'(1) : fill_q;

	assign last_c = (WW'(out_col_q) + WW'(1)) == eff_w;
	assign last_r = ({1'b0, out_row_q} + 17'd1) == {1'b0, eff_h};

	assign cfg_restart = cfg_wr_en &&
		(cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		nb_ok  = 1'b0;
		nb_pix = '0;
		unique case (nb_q)
			3'd0: begin nb_ok = out_row_q != '0;                 nb_pix = win_q[1][0]; end
			3'd1: begin nb_ok = out_row_q != '0 && out_col_q != '0; nb_pix = win_q[0][0]; end
			3'd2: begin nb_ok = out_col_q != '0;                 nb_pix = win_q[0][1]; end
			3'd3: begin nb_ok = !last_r && out_col_q != '0;      nb_pix = win_q[0][2]; end
			3'd4: begin nb_ok = !last_r;                         nb_pix = win_q[1][2]; end
			3'd5: begin nb_ok = !last_r && !last_c;              nb_pix = win_q[2][2]; end
			3'd6: begin nb_ok = !last_c;                         nb_pix = win_q[2][1]; end
			3'd7: begin nb_ok = out_row_q != '0 && !last_c;      nb_pix = win_q[2][0]; end
		endcase
	end

	pnew_wunit u_wunit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.w_start && nb_ok),
		.pix_a  (win_q[1][1]),
		.pix_b  (nb_pix),
		.beta   (beta_q),
		.done   (wu_done),
		.wt     (wu_wt)
	);

	assign wt_now = nb_ok ? wu_wt : 20'd0;

	assign sts.skip     = skip;
	assign sts.emit     = fill_nx >= (FW'(eff_w) + FW'(2));
	assign sts.w_done   = nb_ok ? wu_done : 1'b1;
	assign sts.nb_last  = nb_q == 3'd7;
	assign sts.out_free = !out_valid_q || res_out.ready;

	// line stores: registered read on accept, write on push
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			top_s1 <= far_mem[rd_addr];
			mid_s1 <= near_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			near_mem[in_col_q] <= pix_q;
			far_mem[in_col_q]  <= mid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) pix_q <= is_pix ? {red, green, blue} : 24'd0;
		if (cmd.w_store) wts_q[nb_q] <= wt_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (cmd.push) begin
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= top_s1;
			win_q[2][1] <= mid_s1;
			win_q[2][2] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= DEF_FRAME_WIDTH;
			fh_q   <= DEF_FRAME_HEIGHT;
			beta_q <= DEF_BETA_Q8;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_FRAME_WIDTH) fw_q <= cfg_wdata[11:0];
			if (cfg_index == REG_FRAME_HEIGHT) fh_q <= cfg_wdata[15:0];
			if (cfg_index == REG_BETA_Q8) beta_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
			drain_q   <= 1'b0;
			nb_q      <= '0;
			deg_q     <= '0;
		end else begin
			priority if (cfg_restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				fill_q    <= '0;
				drain_q   <= 1'b0;
			end else if (cmd.accept) begin
				if (restart_now) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					fill_q    <= '0;
					drain_q   <= 1'b0;
				end else if (!is_pix && !skip) begin
					drain_q <= 1'b1;
				end
			end else if (cmd.push) begin
				fill_q <= fill_nx;
				nb_q   <= '0;
				deg_q  <= '0;
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_wrap ? 16'd0 : in_row_q + 16'd1;
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
			end else if (cmd.w_store) begin
				nb_q  <= nb_q + 3'd1;
				deg_q <= deg_q + 23'(wt_now);
			end else if (cmd.out_load) begin
				if (last_c) begin
					out_col_q <= '0;
					if (last_r) begin
						out_row_q <= '0;
						// frame flushed: restart at frame start
						if (drain_q) begin
							in_col_q <= '0;
							in_row_q <= '0;
							fill_q   <= '0;
							drain_q  <= 1'b0;
						end
					end else begin
						out_row_q <= out_row_q + 16'd1;
					end
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_out.w_up          <= wts_q[0];
			res_out.w_up_left     <= wts_q[1];
			res_out.w_left        <= wts_q[2];
			res_out.w_down_left   <= wts_q[3];
			res_out.w_down        <= wts_q[4];
			res_out.w_down_right  <= wts_q[5];
			res_out.w_right       <= wts_q[6];
			res_out.w_up_right    <= wts_q[7];
			res_out.degree        <= deg_q;
			res_out.last_of_frame <= last_c && last_r;
		end
	end

	assign res_out.valid = out_valid_q;
endmodule

>>> rtl/pnew_ctrl.sv
// Controller of the edge weight block: sequences accept, push, the eight
// neighbor weights and the result load; uses pnew_pkg.
module pnew_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output pnew_pkg::cmd_t cmd,
	input  pnew_pkg::sts_t sts
);
	import pnew_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid && !sts.skip) state_nx = C_PUSH;
			end
			C_PUSH: state_nx = sts.emit ? C_WSTART : C_IDLE;
			C_WSTART: state_nx = C_WWAIT;
			C_WWAIT: begin
				if (sts.w_done) state_nx = sts.nb_last ? C_OUT : C_WSTART;
			end
			C_OUT: begin
				if (sts.out_free) state_nx = C_IDLE;
			end
			default: state_nx = C_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			C_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			C_PUSH:   cmd.push = 1'b1;
			C_WSTART: cmd.w_start = 1'b1;
			C_WWAIT:  cmd.w_store = sts.w_done;
			C_OUT:    cmd.out_load = sts.out_free;
			default:  cmd = '0;
		endcase
	end
endmodule

>>> rtl/pixel_neighbor_edge_weights.sv
// Eight-neighbor affinity weights over a raster RGB stream. Each accepted
// item first reads the line stores, then is pushed; an item that yields
// a result then runs one shared iterative weight unit per neighbor. For an
// in-frame neighbor it takes three reciprocal-multiply steps to scale the
// argument, ten Taylor terms of two multiplies each, four squarings and the
// final scale; it stops early when the weight saturates at one, and an
// out-of-frame neighbor gets weight zero without it. A result is delayed while
// the previous result still waits in the output register; the next item is
// taken as soon as the result is loaded. Results lag their center pixel by
// one row plus one pixel; drain items flush a frame's tail.
module pixel_neighbor_edge_weights #(
	parameter int unsigned MAX_WIDTH = pnew_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pnew_in_if.sink     pix_in,
	pnew_out_if.source  res_out,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);
	import pnew_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign pix_in.ready = in_ready;

	pnew_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pnew_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.func      (pix_in.func),
		.red       (pix_in.red),
		.green     (pix_in.green),
		.blue      (pix_in.blue),
		.res_out   (res_out)
	);
endmodule
